FILE: src/sirpf_pkg.sv
// Package for the subset index remapper and pair filter.
// Holds field widths, opcode and status codes, controller states and the
// command and status structs shared by the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none

package sirpf_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned OFS_W  = 16;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned NEW_W  = 10;
  localparam int unsigned KEPT_W = 11;
  localparam int unsigned PAIR_W = 9;

  // Item opcodes; the fourth code is unused and refused.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_KEEP  = 2'd1,
    OP_PAIR  = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK         = 3'd0,
    ST_REPEAT     = 3'd1,
    ST_PAIR_RANGE = 3'd2,
    ST_NOT_KEPT   = 3'd3,
    ST_DUPLICATE  = 3'd4,
    ST_KEEP_RANGE = 3'd5,
    ST_REFUSED    = 3'd6,
    ST_CLEARED    = 3'd7
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_EVAL,
    S_SCAN,
    S_COMMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sweep;
    logic scan_start;
    logic scan;
    logic commit;
    logic post_scan;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_clear;
    logic need_scan;
    logic sweep_last;
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: src/sirpf_ctrl.sv
// Controller state machine of the subset index remapper and pair filter.
// Depends on sirpf_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module sirpf_ctrl
  import sirpf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire dp_sts_t   sts_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  // State register; reset starts the clearing pass over the index map.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = sts_i.in_clear ? S_CLEAR : S_EVAL;
      end
      S_CLEAR: begin
        if (sts_i.sweep_last) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.need_scan) begin
          state_d = S_SCAN;
        end else if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  // Commands and the input stall.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep = 1'b1;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_CLEAR: begin
        cmd_o.sweep = 1'b1;
      end
      S_EVAL: begin
        if (sts_i.need_scan) begin
          cmd_o.scan_start = 1'b1;
        end else begin
          cmd_o.commit = sts_i.out_free;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      S_COMMIT: begin
        cmd_o.post_scan = 1'b1;
        cmd_o.commit    = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // A result is only committed when the output register can take it.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("result committed while the output register is occupied");

  // Once a transaction is taken, the next one waits for its result.
  a_load_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> in_stall_o)
    else $error("input accepted again before the previous item finished");

endmodule

`default_nettype wire

FILE: src/sirpf_dp.sv
// Datapath of the subset index remapper and pair filter: item registers,
// index map memory, pair store memory, counters and the output register.
// Depends on sirpf_pkg for widths, codes and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module sirpf_dp
  import sirpf_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned MAX_PAIRS   = 256
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ctrl_cmd_t               cmd_i,
  output dp_sts_t                      sts_o,
  input  wire logic [CNT_W-1:0]        limit_i,
  input  wire logic [1:0]              opcode_i,
  input  wire logic [IDX_W-1:0]        keep_index_i,
  input  wire logic [IDX_W-1:0]        left_index_i,
  input  wire logic [IDX_W-1:0]        right_index_i,
  input  wire logic signed [OFS_W-1:0] pair_offset_i,
  input  wire logic                    out_stall_i,
  output logic                         out_valid_o,
  output logic [ST_W-1:0]              status_o,
  output logic [NEW_W-1:0]             new_left_o,
  output logic [NEW_W-1:0]             new_right_o,
  output logic signed [OFS_W-1:0]      out_offset_o,
  output logic [KEPT_W-1:0]            kept_glyphs_o,
  output logic [PAIR_W-1:0]            pairs_kept_o
);

  localparam int unsigned MW  = $clog2(MAX_ENTRIES);
  localparam int unsigned NCW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned PCW = $clog2(MAX_PAIRS + 1);
  localparam int unsigned PAW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  // Item registers.
  op_e                     op_q;
  logic [IDX_W-1:0]        keep_q;
  logic [IDX_W-1:0]        left_q;
  logic [IDX_W-1:0]        right_q;
  logic signed [OFS_W-1:0] ofs_q;

  // Index map: a valid bit over the new index.
  logic [MW:0]   map_mem [MAX_ENTRIES];
  logic [MW:0]   ma_q, mb_q;
  logic [MW-1:0] addr_a, addr_b;
  logic          map_we;
  logic [MW-1:0] map_wa;
  logic [MW:0]   map_wd;
  logic [MW-1:0] sweep_q;

  // Pair store and its scan.
  logic [2*MW-1:0] pst_mem [MAX_PAIRS];
  logic [2*MW-1:0] pst_rd_q;
  logic [PCW-1:0]  scan_q;
  logic            rd_vld_q;
  logic            hit_q;
  logic            scan_rd;

  // Architectural state.
  logic [NCW-1:0] next_q, next_d;
  logic [PCW-1:0] pc_q, pc_d;
  logic           err_q, err_d;

  // Decode and result.
  logic           keep_in, left_in, right_in;
  logic           ma_vld, mb_vld;
  logic [MW-1:0]  ma_new, mb_new;
  logic           full;
  logic           keep_new, pair_new;
  status_e        res_st;
  logic [MW-1:0]  res_nl, res_nr;
  logic signed [OFS_W-1:0] res_oo;

  // Output register.
  logic                    out_valid_q;
  status_e                 st_q;
  logic [MW-1:0]           nl_q, nr_q;
  logic signed [OFS_W-1:0] oo_q;
  logic [NCW-1:0]          kg_q;
  logic [PCW-1:0]          pk_q;
  logic                    out_free;

  // Capture the item when the transaction is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(opcode_i);
      keep_q  <= keep_index_i;
      left_q  <= left_index_i;
      right_q <= right_index_i;
      ofs_q   <= pair_offset_i;
    end
  end

  // Map read addresses come straight from the input so the entries are
  // ready in the cycle after acceptance.
  assign addr_a = (opcode_i == OP_KEEP) ? keep_index_i[MW-1:0] : left_index_i[MW-1:0];
  assign addr_b = right_index_i[MW-1:0];

  // The clearing pass and a new keep share the single map write port.
  assign map_we = cmd_i.sweep || keep_new;
  assign map_wa = cmd_i.sweep ? sweep_q : keep_q[MW-1:0];
  assign map_wd = cmd_i.sweep ? '0 : {1'b1, next_q[MW-1:0]};

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (cmd_i.load) begin
      ma_q <= map_mem[addr_a];
      mb_q <= map_mem[addr_b];
    end
  end

  // Clearing pass address; it returns to zero after the last entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= (sweep_q == MW'(MAX_ENTRIES - 1)) ? '0 : sweep_q + MW'(1);
    end
  end

  assign ma_vld   = ma_q[MW];
  assign mb_vld   = mb_q[MW];
  assign ma_new   = ma_q[MW-1:0];
  assign mb_new   = mb_q[MW-1:0];
  assign keep_in  = {1'b0, keep_q} < limit_i;
  assign left_in  = {1'b0, left_q} < limit_i;
  assign right_in = {1'b0, right_q} < limit_i;
  assign full     = (pc_q == PCW'(MAX_PAIRS));

  // Pair store: written at the fill count, read one entry a cycle by the scan.
  assign scan_rd = cmd_i.scan && (scan_q < pc_q);

  always_ff @(posedge clk_i) begin
    if (pair_new) pst_mem[pc_q[PAW-1:0]] <= {ma_new, mb_new};
    if (scan_rd) pst_rd_q <= pst_mem[scan_q[PAW-1:0]];
  end

  // Duplicate scan: one read and one compare a cycle, overlapped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (cmd_i.scan_start) begin
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (cmd_i.scan) begin
      if (scan_rd) scan_q <= scan_q + PCW'(1);
      rd_vld_q <= scan_rd;
      if (rd_vld_q && (pst_rd_q == {ma_new, mb_new})) hit_q <= 1'b1;
    end
  end

  // Result and state update of the item being committed.
  always_comb begin
    res_st   = ST_REFUSED;
    res_nl   = '0;
    res_nr   = '0;
    res_oo   = '0;
    next_d   = next_q;
    pc_d     = pc_q;
    err_d    = err_q;
    keep_new = 1'b0;
    pair_new = 1'b0;
    if (cmd_i.commit) begin
      case (op_q)
        OP_CLEAR: begin
          res_st = ST_CLEARED;
          next_d = '0;
          pc_d   = '0;
          err_d  = 1'b0;
        end
        OP_KEEP: begin
          if (!keep_in) begin
            err_d  = 1'b1;
            res_st = ST_KEEP_RANGE;
          end else if (ma_vld) begin
            res_st = ST_REPEAT;
            res_nl = ma_new;
          end else begin
            keep_new = 1'b1;
            res_nl   = next_q[MW-1:0];
            next_d   = next_q + NCW'(1);
            res_st   = ST_OK;
          end
        end
        OP_PAIR: begin
          if (!cmd_i.post_scan) begin
            if (err_q) begin
              res_st = ST_REFUSED;
            end else if (!left_in || !right_in) begin
              res_st = ST_PAIR_RANGE;
            end else begin
              res_st = ST_NOT_KEPT;
            end
          end else if (hit_q) begin
            res_st = ST_DUPLICATE;
          end else if (full) begin
            res_st = ST_REFUSED;
          end else begin
            pair_new = 1'b1;
            pc_d     = pc_q + PCW'(1);
            res_nl   = ma_new;
            res_nr   = mb_new;
            res_oo   = ofs_q;
            res_st   = ST_OK;
          end
        end
        default: begin
          res_st = ST_REFUSED;
        end
      endcase
    end
  end

  // Counters and the sticky error flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= '0;
      pc_q   <= '0;
      err_q  <= 1'b0;
    end else begin
      next_q <= next_d;
      pc_q   <= pc_d;
      err_q  <= err_d;
    end
  end

  // Output register; it takes a new result when empty or being emptied.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      st_q <= res_st;
      nl_q <= res_nl;
      nr_q <= res_nr;
      oo_q <= res_oo;
      kg_q <= next_d;
      pk_q <= pc_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = st_q;
  assign new_left_o    = NEW_W'(nl_q);
  assign new_right_o   = NEW_W'(nr_q);
  assign out_offset_o  = oo_q;
  assign kept_glyphs_o = KEPT_W'(kg_q);
  assign pairs_kept_o  = PAIR_W'(pk_q);

  // Status towards the controller.
  assign sts_o.in_clear   = (opcode_i == OP_CLEAR);
  assign sts_o.need_scan  = (op_q == OP_PAIR) && !err_q && left_in && right_in &&
                            ma_vld && mb_vld;
  assign sts_o.sweep_last = (sweep_q == MW'(MAX_ENTRIES - 1));
  assign sts_o.scan_done  = hit_q || (!rd_vld_q && (scan_q == pc_q));
  assign sts_o.out_free   = out_free;

  // The pair store never holds more than its depth.
  a_pc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= PCW'(MAX_PAIRS))
    else $error("pair count beyond the store depth");

  // New indices never run past the map depth.
  a_next_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= NCW'(MAX_ENTRIES))
    else $error("new index counter beyond the map depth");

  // Every first keep advances the new index counter by exactly one.
  a_keep_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keep_new |=> next_q == NCW'($past(next_q) + NCW'(1)))
    else $error("first keep did not advance the new index counter");

endmodule

`default_nettype wire

FILE: src/subset_index_remap_pair_filter_core.sv
// Top level of the subset index remapper and pair filter: configuration
// register, count limit, controller and datapath.
// Depends on sirpf_pkg, sirpf_ctrl and sirpf_dp.
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | opcode, keep/left/right index, offset
//   out     | output    | out_valid_o / out_stall_i| status, new indices, offset, counts
//   cfg     | input     | cfg_valid_i / cfg_ready_o| entry count (11 bits)
//
// A keep, a refused pair or an unknown opcode goes from acceptance straight
// to evaluation and commit. A pair that passes the map checks adds a linear
// scan of the pair store, one entry a cycle, that ends early on a match.
// A clear item sweeps the index map, one entry a cycle.
// After reset the same sweep runs before the first item is accepted.
// A stalled output holds its result; the next item is still accepted and
// waits for the output register only when its own result is ready.
`timescale 1ns / 1ps
`default_nettype none

module subset_index_remap_pair_filter_core
  import sirpf_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned MAX_PAIRS   = 256
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_W-1:0]        cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [1:0]              opcode_i,
  input  wire logic [IDX_W-1:0]        keep_index_i,
  input  wire logic [IDX_W-1:0]        left_index_i,
  input  wire logic [IDX_W-1:0]        right_index_i,
  input  wire logic signed [OFS_W-1:0] pair_offset_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [ST_W-1:0]              status_o,
  output logic [NEW_W-1:0]             new_left_o,
  output logic [NEW_W-1:0]             new_right_o,
  output logic signed [OFS_W-1:0]      out_offset_o,
  output logic [KEPT_W-1:0]            kept_glyphs_o,
  output logic [PAIR_W-1:0]            pairs_kept_o
);

  localparam logic [CNT_W-1:0] MaxEnt = CNT_W'(MAX_ENTRIES);

  logic [CNT_W-1:0] limit_q;
  logic [CNT_W-1:0] cfg_ext;
  ctrl_cmd_t        cmd;
  dp_sts_t          sts;

  // Configuration writes are always taken; the stored value is the
  // entry count clipped to the map depth.
  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = CNT_W'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= (cfg_ext > MaxEnt) ? MaxEnt : cfg_ext;
    end
  end

  sirpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sirpf_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .MAX_PAIRS   (MAX_PAIRS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .limit_i       (limit_q),
    .opcode_i      (opcode_i),
    .keep_index_i  (keep_index_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .pair_offset_i (pair_offset_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .new_left_o    (new_left_o),
    .new_right_o   (new_right_o),
    .out_offset_o  (out_offset_o),
    .kept_glyphs_o (kept_glyphs_o),
    .pairs_kept_o  (pairs_kept_o)
  );

endmodule

`default_nettype wire
